FILE: src/two_level_grid_point_binner_macros.svh
// Assertion macros for the two-level grid point binner.
// Used by the checker module; needs no other file.
`ifndef TWO_LEVEL_GRID_POINT_BINNER_MACROS_SVH
`define TWO_LEVEL_GRID_POINT_BINNER_MACROS_SVH

// same-cycle implication
`define TLGPB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlgpb: same-cycle check failed");

// next-cycle implication
`define TLGPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlgpb: next-cycle check failed");

`endif

FILE: src/tlgpb_pkg.sv
// Shared constants, types and functions of the two-level grid point binner.
// No dependencies.
package tlgpb_pkg;

  localparam int unsigned MAX_COARSE_SIDE = 8;
  localparam int unsigned MAX_FINE_SIDE   = 8;
  localparam int unsigned COORD_FRAC_BITS = 32;

  localparam int unsigned COORD_W    = 33;
  localparam int unsigned ID_W       = 40;
  localparam int unsigned CELL_W     = 6;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned QUOTA_W    = 8;
  localparam int unsigned SIDE_CFG_W = 4;
  localparam int unsigned CLAMP_W    = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_COARSE_COLS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COARSE_ROWS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FINE_COLS   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FINE_ROWS   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INIT_QUOTA  = 3'd4;

  typedef struct packed {
    logic [SIDE_CFG_W-1:0] coarse_cols;
    logic [SIDE_CFG_W-1:0] coarse_rows;
    logic [SIDE_CFG_W-1:0] fine_cols;
    logic [SIDE_CFG_W-1:0] fine_rows;
    logic [QUOTA_W-1:0]    init_quota;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]    point_id;
    logic [CELL_W-1:0]  coarse_cell;
    logic [CELL_W-1:0]  fine_cell;
    logic               to_init;
    logic [COUNT_W-1:0] cell_count;
    logic               flush_after;
  } res_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic split;
    logic scale;
    logic index;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_stat_t;

  // zero reads as one, values above the maximum read as the maximum
  function automatic logic [CLAMP_W-1:0] clamp_side(input logic [SIDE_CFG_W-1:0] v,
                                                    input int unsigned maxv);
    logic [CLAMP_W-1:0] r;
    if (v == '0) begin
      r = CLAMP_W'(1);
    end else if (32'(v) > maxv) begin
      r = CLAMP_W'(maxv);
    end else begin
      r = CLAMP_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: src/tlgpb_in_if.sv
// Point input channel: valid/ready handshake with the point payload.
// Depends on tlgpb_pkg.
interface tlgpb_in_if;
  logic                         valid;
  logic                         ready;
  logic [tlgpb_pkg::COORD_W-1:0] x_coord;
  logic [tlgpb_pkg::COORD_W-1:0] y_coord;
  logic                         chunk_end;

  modport source (output valid, output x_coord, output y_coord, output chunk_end,
                  input ready);
  modport sink (input valid, input x_coord, input y_coord, input chunk_end,
                output ready);
endinterface

FILE: src/tlgpb_out_if.sv
// Result output channel: valid/ready handshake with the binning result payload.
// Depends on tlgpb_pkg.
interface tlgpb_out_if;
  logic                          valid;
  logic                          ready;
  logic [tlgpb_pkg::ID_W-1:0]    point_id;
  logic [tlgpb_pkg::CELL_W-1:0]  coarse_cell;
  logic [tlgpb_pkg::CELL_W-1:0]  fine_cell;
  logic                          to_init;
  logic [tlgpb_pkg::COUNT_W-1:0] cell_count;
  logic                          flush_after;

  modport source (output valid, output point_id, output coarse_cell, output fine_cell,
                  output to_init, output cell_count, output flush_after, input ready);
  modport sink (input valid, input point_id, input coarse_cell, input fine_cell,
                input to_init, input cell_count, input flush_after, output ready);
endinterface

FILE: src/two_level_grid_point_binner.sv
// Two-level grid point binner: each accepted point gets the next 40-bit id, its coarse
// and fine cell, and is routed to the cell's init set until the cell has init_quota
// points there, after which the cell's saturating counter counts it. A new point is
// taken only once the last is through: ready drops at the transfer and returns when
// the result is shown. The 6 steps are scale, split, fine scale, index, table read and
// table update (which waits until the last result is taken). They run one after another
// on the single cell table, whose read-modify-write closes before the next point enters.
// The result register lets a new point enter while the last result is still waiting.
// After reset the block sweeps all MAX_COARSE_SIDE^2 * MAX_FINE_SIDE^2 entries (4096 at
// the defaults) of the cell table to zero, one entry per cycle, with ready low;
// configuration writes are taken throughout. Write registers only while idle.
// Depends on tlgpb_pkg, tlgpb_in_if, tlgpb_out_if, tlgpb_ctrl and tlgpb_dp.
module two_level_grid_point_binner #(
  parameter int unsigned MAX_COARSE_SIDE = tlgpb_pkg::MAX_COARSE_SIDE,
  parameter int unsigned MAX_FINE_SIDE   = tlgpb_pkg::MAX_FINE_SIDE,
  parameter int unsigned COORD_FRAC_BITS = tlgpb_pkg::COORD_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  tlgpb_in_if.sink                         point,
  tlgpb_out_if.source                      bin,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tlgpb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tlgpb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tlgpb_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);

  tlgpb_pkg::cfg_t     cfg;
  tlgpb_pkg::dp_cmd_t  cmd;
  tlgpb_pkg::dp_stat_t stat;
  tlgpb_pkg::res_t     res;
  logic                out_valid;
  logic                cfg_we;
  logic [tlgpb_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[tlgpb_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coarse_cols <= tlgpb_pkg::SIDE_CFG_W'(4);
      cfg.coarse_rows <= tlgpb_pkg::SIDE_CFG_W'(4);
      cfg.fine_cols   <= tlgpb_pkg::SIDE_CFG_W'(4);
      cfg.fine_rows   <= tlgpb_pkg::SIDE_CFG_W'(4);
      cfg.init_quota  <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        tlgpb_pkg::REG_COARSE_COLS: cfg.coarse_cols <= pwdata[tlgpb_pkg::SIDE_CFG_W-1:0];
        tlgpb_pkg::REG_COARSE_ROWS: cfg.coarse_rows <= pwdata[tlgpb_pkg::SIDE_CFG_W-1:0];
        tlgpb_pkg::REG_FINE_COLS:   cfg.fine_cols   <= pwdata[tlgpb_pkg::SIDE_CFG_W-1:0];
        tlgpb_pkg::REG_FINE_ROWS:   cfg.fine_rows   <= pwdata[tlgpb_pkg::SIDE_CFG_W-1:0];
        tlgpb_pkg::REG_INIT_QUOTA:  cfg.init_quota  <= pwdata[tlgpb_pkg::QUOTA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tlgpb_pkg::REG_COARSE_COLS: prdata = tlgpb_pkg::APB_DATA_W'(cfg.coarse_cols);
      tlgpb_pkg::REG_COARSE_ROWS: prdata = tlgpb_pkg::APB_DATA_W'(cfg.coarse_rows);
      tlgpb_pkg::REG_FINE_COLS:   prdata = tlgpb_pkg::APB_DATA_W'(cfg.fine_cols);
      tlgpb_pkg::REG_FINE_ROWS:   prdata = tlgpb_pkg::APB_DATA_W'(cfg.fine_rows);
      tlgpb_pkg::REG_INIT_QUOTA:  prdata = tlgpb_pkg::APB_DATA_W'(cfg.init_quota);
      default:                    prdata = '0;
    endcase
  end

  tlgpb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(point.valid),
    .in_ready(point.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  tlgpb_dp #(
    .MAX_COARSE_SIDE(MAX_COARSE_SIDE),
    .MAX_FINE_SIDE  (MAX_FINE_SIDE),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .x_coord  (point.x_coord),
    .y_coord  (point.y_coord),
    .chunk_end(point.chunk_end),
    .out_valid(out_valid),
    .out_ready(bin.ready),
    .res      (res)
  );

  assign bin.valid       = out_valid;
  assign bin.point_id    = res.point_id;
  assign bin.coarse_cell = res.coarse_cell;
  assign bin.fine_cell   = res.fine_cell;
  assign bin.to_init     = res.to_init;
  assign bin.cell_count  = res.cell_count;
  assign bin.flush_after = res.flush_after;

endmodule

FILE: src/tlgpb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlgpb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tlgpb_ctrl.sv
// Controller of the binner: clearing pass, per-point step sequence, output hand-off.
// Depends on tlgpb_pkg.
module tlgpb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlgpb_pkg::dp_stat_t stat,
  output tlgpb_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SPLIT  = 3'd2;
  localparam logic [2:0] S_SCALE  = 3'd3;
  localparam logic [2:0] S_INDEX  = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_UPDATE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_INDEX;
      end
      S_INDEX: begin
        cmd.index  = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: src/tlgpb_dp.sv
// Datapath of the binner: coordinate scaling, cell indexing, cell table, result register.
// Depends on tlgpb_pkg and tlgpb_ram.
module tlgpb_dp #(
  parameter int unsigned MAX_COARSE_SIDE = tlgpb_pkg::MAX_COARSE_SIDE,
  parameter int unsigned MAX_FINE_SIDE   = tlgpb_pkg::MAX_FINE_SIDE,
  parameter int unsigned COORD_FRAC_BITS = tlgpb_pkg::COORD_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tlgpb_pkg::cfg_t               cfg,
  input  tlgpb_pkg::dp_cmd_t            cmd,
  output tlgpb_pkg::dp_stat_t           stat,
  input  logic [tlgpb_pkg::COORD_W-1:0] x_coord,
  input  logic [tlgpb_pkg::COORD_W-1:0] y_coord,
  input  logic                          chunk_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tlgpb_pkg::res_t               res
);

  localparam int unsigned CW  = (COORD_FRAC_BITS + 1 > tlgpb_pkg::COORD_W) ?
                                COORD_FRAC_BITS + 1 : tlgpb_pkg::COORD_W;
  localparam int unsigned RW  = COORD_FRAC_BITS + 1;
  localparam int unsigned SCW = $clog2(MAX_COARSE_SIDE + 1);
  localparam int unsigned SFW = $clog2(MAX_FINE_SIDE + 1);
  localparam int unsigned CIW = (MAX_COARSE_SIDE > 1) ? $clog2(MAX_COARSE_SIDE) : 1;
  localparam int unsigned FIW = (MAX_FINE_SIDE > 1) ? $clog2(MAX_FINE_SIDE) : 1;
  localparam int unsigned SXW = RW + SCW;
  localparam int unsigned SPW = RW + SFW;
  localparam int unsigned COARSE_CELLS = MAX_COARSE_SIDE * MAX_COARSE_SIDE;
  localparam int unsigned FINE_CELLS   = MAX_FINE_SIDE * MAX_FINE_SIDE;
  localparam int unsigned DEPTH        = COARSE_CELLS * FINE_CELLS;
  localparam int unsigned CCW = (COARSE_CELLS > 1) ? $clog2(COARSE_CELLS) : 1;
  localparam int unsigned FCW = (FINE_CELLS > 1) ? $clog2(FINE_CELLS) : 1;
  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MEM_W = tlgpb_pkg::QUOTA_W + tlgpb_pkg::COUNT_W;
  localparam logic [CW-1:0] FULL_SIDE = CW'(1) << COORD_FRAC_BITS;

  function automatic logic [RW-1:0] sat_coord(input logic [tlgpb_pkg::COORD_W-1:0] c);
    logic [CW-1:0] ce;
    ce = CW'(c);
    return (ce > FULL_SIDE) ? RW'(FULL_SIDE) : RW'(ce);
  endfunction

  logic [SCW-1:0] ncc, ncr;
  logic [SFW-1:0] nfc, nfr;

  logic [tlgpb_pkg::ID_W-1:0] next_id, id_reg;
  logic                       chunk_reg;
  logic [SXW-1:0]             scaled_x, scaled_y;
  logic [SCW:0]               hx, hy;
  logic [CIW-1:0]             cix_c, ciy_c, cix, ciy;
  logic [RW-1:0]              remx, remy;
  logic [SPW-1:0]             prodx, prody;
  logic [CCW-1:0]             coarse;
  logic [SFW:0]               fhx, fhy;
  logic [FIW-1:0]             fix_c, fiy_c;
  logic [FCW-1:0]             fine;
  logic [AW-1:0]              base, slot, clr_addr;

  logic [MEM_W-1:0]                 rdata, wdata;
  logic [tlgpb_pkg::QUOTA_W-1:0]    taken, taken_new;
  logic [tlgpb_pkg::COUNT_W-1:0]    cnt, cnt_new;
  logic                             go_init;

  assign ncc = SCW'(tlgpb_pkg::clamp_side(cfg.coarse_cols, MAX_COARSE_SIDE));
  assign ncr = SCW'(tlgpb_pkg::clamp_side(cfg.coarse_rows, MAX_COARSE_SIDE));
  assign nfc = SFW'(tlgpb_pkg::clamp_side(cfg.fine_cols, MAX_FINE_SIDE));
  assign nfr = SFW'(tlgpb_pkg::clamp_side(cfg.fine_rows, MAX_FINE_SIDE));

  // coarse index, clamped at the high edge
  assign hx    = scaled_x[SXW-1:COORD_FRAC_BITS];
  assign hy    = scaled_y[SXW-1:COORD_FRAC_BITS];
  assign cix_c = (hx >= (SCW + 1)'(ncc)) ? CIW'(ncc - SCW'(1)) : CIW'(hx);
  assign ciy_c = (hy >= (SCW + 1)'(ncr)) ? CIW'(ncr - SCW'(1)) : CIW'(hy);

  // fine index, clamped at the high edge
  assign fhx   = prodx[SPW-1:COORD_FRAC_BITS];
  assign fhy   = prody[SPW-1:COORD_FRAC_BITS];
  assign fix_c = (fhx >= (SFW + 1)'(nfc)) ? FIW'(nfc - SFW'(1)) : FIW'(fhx);
  assign fiy_c = (fhy >= (SFW + 1)'(nfr)) ? FIW'(nfr - SFW'(1)) : FIW'(fhy);

  assign slot = base + AW'(fine);

  assign taken     = rdata[MEM_W-1:tlgpb_pkg::COUNT_W];
  assign cnt       = rdata[tlgpb_pkg::COUNT_W-1:0];
  assign go_init   = taken < cfg.init_quota;
  assign taken_new = go_init ? taken + 1'b1 : taken;
  assign cnt_new   = (!go_init && cnt != tlgpb_pkg::COUNT_MAX) ? cnt + 1'b1 : cnt;
  assign wdata     = cmd.clear ? '0 : {taken_new, cnt_new};

  assign stat.clear_last = clr_addr == AW'(DEPTH - 1);
  assign stat.out_free   = !out_valid || out_ready;

  tlgpb_ram #(
    .WIDTH(MEM_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (cmd.clear || cmd.commit),
    .waddr(cmd.clear ? clr_addr : slot),
    .wdata(wdata),
    .raddr(slot),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      next_id   <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        next_id <= next_id + 1'b1;
      end
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scaled_x  <= SXW'(sat_coord(x_coord)) * SXW'(ncc);
      scaled_y  <= SXW'(sat_coord(y_coord)) * SXW'(ncr);
      id_reg    <= next_id;
      chunk_reg <= chunk_end;
    end
    if (cmd.split) begin
      cix  <= cix_c;
      ciy  <= ciy_c;
      remx <= RW'(scaled_x - (SXW'(cix_c) << COORD_FRAC_BITS));
      remy <= RW'(scaled_y - (SXW'(ciy_c) << COORD_FRAC_BITS));
    end
    if (cmd.scale) begin
      prodx  <= SPW'(remx) * SPW'(nfc);
      prody  <= SPW'(remy) * SPW'(nfr);
      coarse <= CCW'(CCW'(ciy) * CCW'(ncc) + CCW'(cix));
    end
    if (cmd.index) begin
      fine <= FCW'(FCW'(fiy_c) * FCW'(nfc) + FCW'(fix_c));
      base <= AW'(coarse) * AW'(FINE_CELLS);
    end
    if (cmd.commit) begin
      res.point_id    <= id_reg;
      res.coarse_cell <= tlgpb_pkg::CELL_W'(coarse);
      res.fine_cell   <= tlgpb_pkg::CELL_W'(fine);
      res.to_init     <= go_init;
      res.cell_count  <= cnt_new;
      res.flush_after <= chunk_reg;
    end
  end

endmodule

FILE: src/tlgpb_chk.sv
// Port-level checker for the two-level grid point binner, bound to the top level.
// Depends on tlgpb_pkg and two_level_grid_point_binner_macros.svh.
`include "two_level_grid_point_binner_macros.svh"

module tlgpb_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          to_init,
  input logic [tlgpb_pkg::COUNT_W-1:0] cell_count,
  input logic [tlgpb_pkg::ID_W-1:0]    point_id
);

  // table sweep keeps the input closed right after reset
  `TLGPB_ASSERT_NOW(a_clear_after_reset, clk, rst, $fell(rst), !in_ready)

  // one point at a time
  `TLGPB_ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && in_ready, !in_ready)

  // a counted point leaves a nonzero count
  `TLGPB_ASSERT_NOW(a_counted_nonzero, clk, rst, out_valid && !to_init, cell_count != '0)

  `TLGPB_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready,
                     out_valid && $stable(point_id))

endmodule

bind two_level_grid_point_binner tlgpb_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (point.valid),
  .in_ready  (point.ready),
  .out_valid (bin.valid),
  .out_ready (bin.ready),
  .to_init   (bin.to_init),
  .cell_count(bin.cell_count),
  .point_id  (bin.point_id)
);
